// ===== rtl/core/lsdf_pkg.sv =====
// Shared types, constants and helper functions of the local standard deviation filter.
// Used by lsdf_front, lsdf_back and local_std_dev_filter; depends on nothing else.
package lsdf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_RADIUS  = 3;
    localparam int STORE_ROWS  = 2 * MAX_RADIUS + 2;
    localparam int STORE_DEPTH = MAX_WIDTH * STORE_ROWS;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(STORE_ROWS);
    localparam int ADDR_W = COL_W + ROW_W;

    localparam int W_W   = 11;
    localparam int H_W   = 13;
    localparam int R_W   = 2;
    localparam int CFG_W = 13;
    localparam int CNT_W = 24;
    localparam int LAG_W = 14;
    localparam int Q_DEPTH = 2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam int NUM_W  = 28;
    localparam int ROOT_W = 48;

    typedef struct packed {
        logic [W_W-1:0] w;
        logic [H_W-1:0] h;
        logic [R_W-1:0] r;
    } t_cfg;

    typedef struct packed {
        logic [W_W-1:0] ox;
        logic [H_W-1:0] oy;
        logic           last;
    } t_job;

    typedef struct packed {
        logic   vld;
        t_job   job;
    } t_q_head;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic pop;
        logic rd_busy;
    } t_bk_stat;

    function automatic logic [5:0] win_n(logic [R_W-1:0] r);
        logic [5:0] n;
        case (r)
            2'd1:    n = 6'd9;
            2'd2:    n = 6'd25;
            default: n = 6'd49;
        endcase
        return n;
    endfunction

    function automatic logic [NUM_W-1:0] win_den(logic [R_W-1:0] r);
        logic [NUM_W-1:0] d;
        case (r)
            2'd1:    d = NUM_W'(9 * 8 * 65025);
            2'd2:    d = NUM_W'(25 * 24 * 65025);
            default: d = NUM_W'(49 * 48 * 65025);
        endcase
        return d;
    endfunction

    function automatic logic [H_W-1:0] reflect(logic signed [14:0] idx, logic [H_W-1:0] n);
        logic signed [14:0] v;
        logic signed [14:0] sn;
        sn = signed'({2'b00, n});
        v  = idx;
        if (v < 15'sd0) v = -v - 15'sd1;
        if (v >= sn) v = 15'sd2 * sn - 15'sd1 - v;
        if (v < 15'sd0) v = 15'sd0;
        if (v >= sn) v = sn - 15'sd1;
        return v[H_W-1:0];
    endfunction

endpackage

// ===== rtl/core/local_std_dev_filter.sv =====
// Local standard deviation filter over a square window of one 8-bit grey channel.
// The input channel takes pixel and drain beats; the output channel gives one
// 16-bit deviation per window, as a fraction of full scale, with a frame end flag.
// Results lag the pixel stream by R rows plus R pixels; drain beats flush the tail.
// Each result takes line store reads, one per window entry, then sums and products
// and a digit-serial square root that folds in the normalizing division; the back
// end takes the next job only once its last result is in the output register.
// A pixel beat is taken only when no window is queued or being read, so the
// line store is never overwritten under a pending window; drain beats may queue
// up to two jobs ahead of the back end.
// A finished result waits in the output register while the receiver stalls; then
// the back end holds the next one, drain beats are taken until the job queue fills
// and pixel beats wait until the queue is empty.
// Configuration writes are taken at any edge with the write enable high and
// restart the frame; write them only while the block is idle.
// Synchronous active-low reset clears counters, queue and output valid and loads
// width 640, height 480, radius 1; the line store is not cleared.
// Depends on lsdf_pkg, lsdf_front and lsdf_back.
module local_std_dev_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [lsdf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_req_type,
    input  logic [7:0]                 i_pixel_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [15:0]                o_std_value,
    output logic                       o_frame_end
);

    lsdf_pkg::t_bk_stat bk_stat;
    lsdf_pkg::t_q_head  q_head;
    lsdf_pkg::t_cfg     cfg;
    lsdf_pkg::t_wr      wr;

    lsdf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_pixel_value (i_pixel_value),
        .i_bk_stat     (bk_stat),
        .o_q_head      (q_head),
        .o_cfg         (cfg),
        .o_wr          (wr)
    );

    lsdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_wr        (wr),
        .i_q_head    (q_head),
        .o_bk_stat   (bk_stat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_std_value (o_std_value),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== rtl/core/lsdf_front.sv =====
// Front end of the filter: configuration registers, frame counters, line store writes
// and the job queue toward the back end. Depends on lsdf_pkg.
module lsdf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [lsdf_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [7:0]                    i_pixel_value,
    input  lsdf_pkg::t_bk_stat            i_bk_stat,
    output lsdf_pkg::t_q_head             o_q_head,
    output lsdf_pkg::t_cfg                o_cfg,
    output lsdf_pkg::t_wr                 o_wr
);

    logic [lsdf_pkg::W_W-1:0]   r_width;
    logic [lsdf_pkg::H_W-1:0]   r_height;
    logic [lsdf_pkg::R_W-1:0]   r_radius;
    logic [lsdf_pkg::CNT_W-1:0] r_in_cnt, r_out_cnt;
    logic [lsdf_pkg::W_W-1:0]   r_ix, r_ox;
    logic [lsdf_pkg::H_W-1:0]   r_iy, r_oy;
    lsdf_pkg::t_job             r_q [lsdf_pkg::Q_DEPTH];
    logic                       r_q_wp, r_q_rp;
    logic [1:0]                 r_q_cnt;

    lsdf_pkg::t_cfg             cfg;
    logic [lsdf_pkg::CNT_W-1:0] total;
    logic [lsdf_pkg::LAG_W-1:0] lag;
    logic                       accept, do_wr, emit, last;
    logic [lsdf_pkg::CNT_W-1:0] n_in_cnt, pend;
    logic                       push;

    always_comb begin
        cfg.w = (r_width == '0) ? lsdf_pkg::W_W'(1) :
                (r_width > lsdf_pkg::W_W'(lsdf_pkg::MAX_WIDTH)) ?
                lsdf_pkg::W_W'(lsdf_pkg::MAX_WIDTH) : r_width;
        cfg.h = (r_height == '0) ? lsdf_pkg::H_W'(1) : r_height;
        cfg.r = (r_radius == '0) ? lsdf_pkg::R_W'(1) :
                (r_radius > lsdf_pkg::R_W'(lsdf_pkg::MAX_RADIUS)) ?
                lsdf_pkg::R_W'(lsdf_pkg::MAX_RADIUS) : r_radius;
        total = lsdf_pkg::CNT_W'(cfg.w) * lsdf_pkg::CNT_W'(cfg.h);
        lag   = lsdf_pkg::LAG_W'(cfg.r) * lsdf_pkg::LAG_W'(cfg.w) + lsdf_pkg::LAG_W'(cfg.r);
    end

    assign o_cfg = cfg;

    assign o_ready = (r_q_cnt < 2'(lsdf_pkg::Q_DEPTH)) &&
                     ((i_req_type == lsdf_pkg::REQ_DRAIN) ||
                      ((r_q_cnt == 2'd0) && !i_bk_stat.rd_busy));
    assign accept  = i_valid && o_ready;

    always_comb begin
        do_wr    = accept && (i_req_type == lsdf_pkg::REQ_PIXEL) && (r_in_cnt < total);
        n_in_cnt = r_in_cnt + lsdf_pkg::CNT_W'(do_wr);
        pend     = n_in_cnt - r_out_cnt;
        emit     = accept && (r_out_cnt < n_in_cnt) &&
                   ((n_in_cnt == total) || (pend > lsdf_pkg::CNT_W'(lag)));
        last     = (r_out_cnt + lsdf_pkg::CNT_W'(1)) == total;
        push     = emit;
    end

    assign o_wr.en   = do_wr;
    assign o_wr.addr = {r_iy[lsdf_pkg::ROW_W-1:0], r_ix[lsdf_pkg::COL_W-1:0]};
    assign o_wr.data = i_pixel_value;

    assign o_q_head.vld = (r_q_cnt != 2'd0);
    assign o_q_head.job = r_q[r_q_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_q_wp] <= '{ox: r_ox, oy: r_oy, last: last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= lsdf_pkg::W_W'(640);
            r_height  <= lsdf_pkg::H_W'(480);
            r_radius  <= lsdf_pkg::R_W'(1);
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_ix      <= '0;
            r_iy      <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_q_wp    <= 1'b0;
            r_q_rp    <= 1'b0;
            r_q_cnt   <= '0;
        end else begin
            if (push) r_q_wp <= ~r_q_wp;
            if (i_bk_stat.pop) r_q_rp <= ~r_q_rp;
            r_q_cnt <= r_q_cnt + 2'(push) - 2'(i_bk_stat.pop);

            if (i_cfg_we && (i_cfg_idx == lsdf_pkg::CFG_WIDTH || i_cfg_idx == lsdf_pkg::CFG_HEIGHT
                             || i_cfg_idx == lsdf_pkg::CFG_RADIUS)) begin
                case (i_cfg_idx)
                    lsdf_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[lsdf_pkg::W_W-1:0];
                    lsdf_pkg::CFG_HEIGHT: r_height <= i_cfg_data[lsdf_pkg::H_W-1:0];
                    default:              r_radius <= i_cfg_data[lsdf_pkg::R_W-1:0];
                endcase
                r_in_cnt  <= '0;
                r_out_cnt <= '0;
                r_ix      <= '0;
                r_iy      <= '0;
                r_ox      <= '0;
                r_oy      <= '0;
            end else if (emit && last) begin
                r_in_cnt  <= '0;
                r_out_cnt <= '0;
                r_ix      <= '0;
                r_iy      <= '0;
                r_ox      <= '0;
                r_oy      <= '0;
            end else begin
                r_in_cnt <= n_in_cnt;
                if (do_wr) begin
                    if (r_ix + lsdf_pkg::W_W'(1) == cfg.w) begin
                        r_ix <= '0;
                        r_iy <= r_iy + lsdf_pkg::H_W'(1);
                    end else begin
                        r_ix <= r_ix + lsdf_pkg::W_W'(1);
                    end
                end
                if (emit) begin
                    r_out_cnt <= r_out_cnt + lsdf_pkg::CNT_W'(1);
                    if (r_ox + lsdf_pkg::W_W'(1) == cfg.w) begin
                        r_ox <= '0;
                        r_oy <= r_oy + lsdf_pkg::H_W'(1);
                    end else begin
                        r_ox <= r_ox + lsdf_pkg::W_W'(1);
                    end
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= 2'(lsdf_pkg::Q_DEPTH))
        else $error("Job queue count exceeds its depth.");
    a_wr_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_wr |-> (!i_bk_stat.rd_busy && r_q_cnt == 2'd0))
        else $error("Line store written while a window is still pending.");
    a_cnt_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt <= r_in_cnt)
        else $error("More results issued than pixels received.");
`endif

endmodule

// ===== rtl/core/lsdf_back.sv =====
// Back end of the filter: line store, window accumulation, a digit-serial square root
// that folds in the normalizing division, and the output register. Depends on lsdf_pkg.
module lsdf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsdf_pkg::t_cfg     i_cfg,
    input  lsdf_pkg::t_wr      i_wr,
    input  lsdf_pkg::t_q_head  i_q_head,
    output lsdf_pkg::t_bk_stat o_bk_stat,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_std_value,
    output logic               o_frame_end
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUB  = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [7:0]                       r_mem [lsdf_pkg::STORE_DEPTH];
    logic [2:0]                       r_state;
    logic [lsdf_pkg::W_W-1:0]         r_ox;
    logic [lsdf_pkg::H_W-1:0]         r_oy;
    logic                             r_last;
    logic [2:0]                       r_dx, r_dy;
    logic [7:0]                       r_rdata;
    logic                             r_rvld;
    logic [13:0]                      r_s1;
    logic [21:0]                      r_s2;
    logic [lsdf_pkg::NUM_W-1:0]       r_a, r_b;
    logic [lsdf_pkg::ROOT_W-1:0]      r_rem, r_sd;
    logic [3:0]                       r_step;
    logic [15:0]                      r_res;

    logic [2:0]                       span;
    logic [lsdf_pkg::H_W-1:0]         yy, xx;
    logic [lsdf_pkg::ADDR_W-1:0]      rd_addr;
    logic [lsdf_pkg::ROOT_W-1:0]      den;
    logic [lsdf_pkg::ROOT_W-1:0]      rem4, trial;
    logic                             pop, out_free;

    assign span     = {i_cfg.r, 1'b0};
    assign den      = lsdf_pkg::ROOT_W'(lsdf_pkg::win_den(i_cfg.r));
    assign pop      = (r_state == ST_IDLE) && i_q_head.vld;
    assign out_free = !o_valid || i_ready;

    assign o_bk_stat.pop     = pop;
    assign o_bk_stat.rd_busy = (r_state == ST_ACC) || (r_state == ST_WAIT);

    // The root s is the largest value with s*s*den <= num * 2^32; r_sd holds s*den and
    // r_rem the remainder at the current digit, so no division is needed.
    always_comb begin
        yy = lsdf_pkg::reflect(signed'({2'b00, r_oy}) + signed'({12'b0, r_dy})
                               - signed'({13'b0, i_cfg.r}), i_cfg.h);
        xx = lsdf_pkg::reflect(signed'({4'b0, r_ox}) + signed'({12'b0, r_dx})
                               - signed'({13'b0, i_cfg.r}), {2'b00, i_cfg.w});
        rd_addr = {yy[lsdf_pkg::ROW_W-1:0], xx[lsdf_pkg::COL_W-1:0]};
        rem4    = {r_rem[lsdf_pkg::ROOT_W-3:0], 2'b00};
        trial   = {r_sd[lsdf_pkg::ROOT_W-3:0], 2'b00} + den;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ox   <= i_q_head.job.ox;
            r_oy   <= i_q_head.job.oy;
            r_last <= i_q_head.job.last;
            r_s1   <= '0;
            r_s2   <= '0;
        end else if (r_rvld) begin
            r_s1 <= r_s1 + 14'(r_rdata);
            r_s2 <= r_s2 + 22'(16'(r_rdata) * 16'(r_rdata));
        end
        case (r_state)
            ST_MUL: begin
                r_a <= lsdf_pkg::NUM_W'(lsdf_pkg::win_n(i_cfg.r)) * lsdf_pkg::NUM_W'(r_s2);
                r_b <= lsdf_pkg::NUM_W'(r_s1) * lsdf_pkg::NUM_W'(r_s1);
            end
            ST_SUB: begin
                r_rem <= lsdf_pkg::ROOT_W'(r_a - r_b);
                r_sd  <= '0;
                r_res <= '0;
            end
            ST_ROOT: begin
                if (rem4 >= trial) begin
                    r_rem <= rem4 - trial;
                    r_sd  <= {r_sd[lsdf_pkg::ROOT_W-2:0], 1'b0} + den;
                    r_res <= {r_res[14:0], 1'b1};
                end else begin
                    r_rem <= rem4;
                    r_sd  <= {r_sd[lsdf_pkg::ROOT_W-2:0], 1'b0};
                    r_res <= {r_res[14:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
        if (r_state == ST_DONE && out_free) begin
            o_std_value <= r_res;
            o_frame_end <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dx    <= '0;
            r_dy    <= '0;
            r_rvld  <= 1'b0;
            r_step  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_rvld <= (r_state == ST_ACC);
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_dx <= '0;
                    r_dy <= '0;
                    if (pop) r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_dx == span) begin
                        r_dx <= '0;
                        r_dy <= r_dy + 3'd1;
                        if (r_dy == span) r_state <= ST_WAIT;
                    end else begin
                        r_dx <= r_dx + 3'd1;
                    end
                end
                ST_WAIT: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_SUB;
                ST_SUB: begin
                    r_step  <= '0;
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |-> (r_rem < ({r_sd[lsdf_pkg::ROOT_W-2:0], 1'b0} + den)))
        else $error("Square root remainder is out of range.");
    a_rd_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvld |-> (r_state == ST_ACC || r_state == ST_WAIT))
        else $error("Store read data arrives outside the accumulation phase.");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_DONE))
        else $error("Result presented without a finished computation.");
`endif

endmodule
